/* rtl/basic_line_lexer_core_defines.svh */
// Assertion helpers used by the lexer's output queue (bll_ofifo).
`ifndef BASIC_LINE_LEXER_CORE_DEFINES_SVH
`define BASIC_LINE_LEXER_CORE_DEFINES_SVH

// Implication checked on every rising clock edge out of reset.
`define BLL_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked out of reset.
`define BLL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/bll_pkg.sv */
package bll_pkg;

    localparam logic [3:0] KIND_NUMBER  = 4'd0;
    localparam logic [3:0] KIND_OPER    = 4'd1;
    localparam logic [3:0] KIND_KEYWORD = 4'd2;
    localparam logic [3:0] KIND_VAR     = 4'd3;
    localparam logic [3:0] KIND_QCHAR   = 4'd4;
    localparam logic [3:0] KIND_QEND    = 4'd5;
    localparam logic [3:0] KIND_BRACKET = 4'd6;
    localparam logic [3:0] KIND_HASH    = 4'd7;
    localparam logic [3:0] KIND_EOL     = 4'd8;
    localparam logic [3:0] KIND_ERROR   = 4'd9;

    localparam logic [13:0] ERR_KEYWORD = 14'd0;
    localparam logic [13:0] ERR_SYMBOL  = 14'd1;
    localparam logic [13:0] ERR_NUMBER  = 14'd2;
    localparam logic [13:0] ERR_WORD    = 14'd3;
    localparam logic [13:0] ERR_QUOTE   = 14'd4;

    localparam logic [13:0] NUM_CAP = 14'd9999;

    localparam int KW_COUNT  = 8;
    localparam int KW_MAXLEN = 6;

    localparam logic [7:0] KW_CHAR [KW_COUNT][KW_MAXLEN] = '{
        '{"i", "n", "p", "u", "t", 8'h00},
        '{"p", "r", "i", "n", "t", 8'h00},
        '{"l", "e", "t", 8'h00, 8'h00, 8'h00},
        '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"g", "o", "t", "o", 8'h00, 8'h00},
        '{"e", "n", "d", 8'h00, 8'h00, 8'h00},
        '{"g", "o", "s", "u", "b", 8'h00},
        '{"r", "e", "t", "u", "r", "n"}
    };

    localparam logic [2:0] KW_LEN [KW_COUNT] = '{
        3'd5, 3'd5, 3'd3, 3'd2, 3'd4, 3'd3, 3'd5, 3'd6
    };

    typedef struct packed {
        logic [3:0]  kind;
        logic [13:0] value;
        logic [7:0]  symbol;
        logic        last;
    } t_res;

endpackage

/* rtl/basic_line_lexer_core.sv */
// Line lexer: one character transaction per cycle in while the result queue has room, tokens out.
// Path: each character is registered in r_ch, then lexed into the result queue at the output.
// Throughput: one character per cycle while the queue has room for two results; a character yielding
// two tokens writes both into the queue together, which then offers them on the output one at a time.
// Reset: synchronous active-low i_rst_n returns the lexer to idle and empties the queue.
module basic_line_lexer_core #(
    parameter int MAX_NUMBER_CHARS = 4,
    parameter int MAX_WORD_CHARS   = 6
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_ch,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [3:0]  o_kind,
    output logic [13:0] o_value,
    output logic [7:0]  o_symbol,
    output logic        o_last
);

    logic          r_ch_vld;
    logic [7:0]    r_ch;
    logic          room2;
    logic          fire;
    bll_pkg::t_res res0, res1, head;
    logic [1:0]    res_cnt;

    assign fire    = r_ch_vld && room2;
    assign o_ready = !r_ch_vld || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ch_vld <= 1'b0;
        end else if (o_ready) begin
            r_ch_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_ch <= i_ch;
        end
    end

    bll_lexer #(
        .MAX_NUMBER_CHARS(MAX_NUMBER_CHARS),
        .MAX_WORD_CHARS  (MAX_WORD_CHARS)
    ) u_lexer (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_ch     (r_ch),
        .o_res0   (res0),
        .o_res1   (res1),
        .o_res_cnt(res_cnt)
    );

    bll_ofifo u_ofifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_res0    (res0),
        .i_res1    (res1),
        .i_push_cnt(res_cnt),
        .o_room2   (room2),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_res     (head)
    );

    assign o_kind   = head.kind;
    assign o_value  = head.value;
    assign o_symbol = head.symbol;
    assign o_last   = head.last;

endmodule

/* rtl/bll_lexer.sv */
module bll_lexer #(
    parameter int MAX_NUMBER_CHARS = 4,
    parameter int MAX_WORD_CHARS   = 6
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_fire,
    input  logic [7:0]    i_ch,
    output bll_pkg::t_res o_res0,
    output bll_pkg::t_res o_res1,
    output logic [1:0]    o_res_cnt
);

    localparam int NLW = $clog2(MAX_NUMBER_CHARS + 1);
    localparam int WLW = $clog2(MAX_WORD_CHARS + 1);
    localparam int WIW = $clog2(MAX_WORD_CHARS);

    localparam logic [2:0] MODE_IDLE  = 3'd0;
    localparam logic [2:0] MODE_NUM   = 3'd1;
    localparam logic [2:0] MODE_WORD  = 3'd2;
    localparam logic [2:0] MODE_QUOTE = 3'd3;
    localparam logic [2:0] MODE_HALT  = 3'd4;

    logic [2:0]       r_mode, n_mode;
    logic [13:0]      r_num_acc, n_num_acc;
    logic [NLW-1:0]   r_num_len, n_num_len;
    logic             r_num_done, n_num_done;
    logic [WLW-1:0]   r_word_len, n_word_len;
    logic             r_line_tok, n_line_tok;
    logic [7:0]       r_word [MAX_WORD_CHARS];

    logic             wr_en;
    logic [WIW-1:0]   wr_idx;
    logic [7:0]       wr_data;

    logic             kw_hit;
    logic [2:0]       kw_code;

    bll_pkg::t_res    res0, res1, tail_res;
    logic [1:0]       res_cnt;

    function automatic logic is_letter(input logic [7:0] c);
        return (c inside {[8'h61:8'h7a], [8'h41:8'h5a]});
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c inside {[8'h30:8'h39]});
    endfunction

    function automatic logic is_delim(input logic [7:0] c);
        return (c inside {"(", ")", "=", "/", "*", "+", "-", " ", 8'd10, 8'd0, 8'h22});
    endfunction

    function automatic bll_pkg::t_res mk(input logic [3:0] kind, input logic [13:0] value,
                                         input logic [7:0] symbol);
        bll_pkg::t_res r;
        r.kind   = kind;
        r.value  = value;
        r.symbol = symbol;
        r.last   = 1'b0;
        return r;
    endfunction

    always_comb begin
        logic m;
        kw_hit  = 1'b0;
        kw_code = 3'd0;
        for (int k = bll_pkg::KW_COUNT - 1; k >= 0; k--) begin
            m = (r_word_len == WLW'(bll_pkg::KW_LEN[k]));
            for (int j = 0; j < bll_pkg::KW_MAXLEN; j++) begin
                if (j < int'(bll_pkg::KW_LEN[k]) && r_word[j] != bll_pkg::KW_CHAR[k][j]) begin
                    m = 1'b0;
                end
            end
            if (m) begin
                kw_hit  = 1'b1;
                kw_code = 3'(k);
            end
        end
    end

    always_comb begin
        logic        line_end;
        logic        do_tail;
        logic        tail_vld;
        logic [16:0] acc_ext;
        line_end   = (i_ch == 8'd0) || (i_ch == 8'd10);
        acc_ext    = 17'(r_num_acc) * 17'd10 + 17'(i_ch[3:0]);
        n_mode     = r_mode;
        n_num_acc  = r_num_acc;
        n_num_len  = r_num_len;
        n_num_done = r_num_done;
        n_word_len = r_word_len;
        n_line_tok = r_line_tok;
        wr_en      = 1'b0;
        wr_idx     = r_word_len[WIW-1:0];
        wr_data    = i_ch;
        res0       = '0;
        res1       = '0;
        tail_res   = '0;
        res_cnt    = 2'd0;
        do_tail    = 1'b0;
        tail_vld   = 1'b0;

        case (r_mode)
            MODE_HALT: begin
                if (line_end) begin
                    n_mode     = MODE_IDLE;
                    n_num_acc  = '0;
                    n_num_len  = '0;
                    n_num_done = 1'b0;
                    n_word_len = '0;
                    n_line_tok = 1'b0;
                end
            end
            MODE_QUOTE: begin
                res_cnt = 2'd1;
                if (line_end) begin
                    res0       = mk(bll_pkg::KIND_ERROR, bll_pkg::ERR_QUOTE, 8'd0);
                    n_mode     = MODE_IDLE;
                    n_num_acc  = '0;
                    n_num_len  = '0;
                    n_num_done = 1'b0;
                    n_word_len = '0;
                    n_line_tok = 1'b0;
                end else if (i_ch == 8'h22) begin
                    res0       = mk(bll_pkg::KIND_QEND, 14'd0, 8'd0);
                    n_mode     = MODE_IDLE;
                    n_line_tok = 1'b1;
                end else begin
                    res0       = mk(bll_pkg::KIND_QCHAR, 14'd0, (i_ch == "#") ? 8'd10 : i_ch);
                    n_line_tok = 1'b1;
                end
            end
            MODE_NUM: begin
                if (!(is_delim(i_ch) || is_letter(i_ch))) begin
                    if (r_num_len >= NLW'(MAX_NUMBER_CHARS)) begin
                        res0    = mk(bll_pkg::KIND_ERROR, bll_pkg::ERR_NUMBER, 8'd0);
                        res_cnt = 2'd1;
                        n_mode  = MODE_HALT;
                    end else begin
                        n_num_len = r_num_len + NLW'(1);
                        if (is_digit(i_ch) && !r_num_done) begin
                            n_num_acc = (acc_ext > 17'(bll_pkg::NUM_CAP)) ? bll_pkg::NUM_CAP
                                                                          : acc_ext[13:0];
                        end else begin
                            n_num_done = 1'b1;
                        end
                    end
                end else begin
                    res0       = mk(bll_pkg::KIND_NUMBER, r_num_acc, 8'd0);
                    res_cnt    = 2'd1;
                    n_line_tok = 1'b1;
                    n_mode     = MODE_IDLE;
                    do_tail    = 1'b1;
                end
            end
            MODE_WORD: begin
                if (!line_end && is_letter(i_ch)) begin
                    if (r_word_len >= WLW'(MAX_WORD_CHARS)) begin
                        res0    = mk(bll_pkg::KIND_ERROR, bll_pkg::ERR_WORD, 8'd0);
                        res_cnt = 2'd1;
                        n_mode  = MODE_HALT;
                    end else begin
                        wr_en      = 1'b1;
                        n_word_len = r_word_len + WLW'(1);
                    end
                end else if (r_word_len != WLW'(1) && !kw_hit) begin
                    res0    = mk(bll_pkg::KIND_ERROR, bll_pkg::ERR_KEYWORD, 8'd0);
                    res_cnt = 2'd1;
                    n_mode  = MODE_HALT;
                    if (line_end) begin
                        n_mode     = MODE_IDLE;
                        n_num_acc  = '0;
                        n_num_len  = '0;
                        n_num_done = 1'b0;
                        n_word_len = '0;
                        n_line_tok = 1'b0;
                    end
                end else begin
                    if (r_word_len == WLW'(1)) begin
                        res0 = mk(bll_pkg::KIND_VAR, 14'd0, r_word[0]);
                    end else begin
                        res0 = mk(bll_pkg::KIND_KEYWORD, 14'(kw_code), 8'd0);
                    end
                    res_cnt    = 2'd1;
                    n_line_tok = 1'b1;
                    n_word_len = '0;
                    n_mode     = MODE_IDLE;
                    do_tail    = 1'b1;
                end
            end
            MODE_IDLE: begin
                do_tail = 1'b1;
            end
            default: begin
                n_mode = MODE_IDLE;
            end
        endcase

        if (do_tail) begin
            if (line_end) begin
                if (n_line_tok) begin
                    tail_vld = 1'b1;
                    tail_res = mk(bll_pkg::KIND_EOL, 14'd0, 8'd0);
                end
                n_mode     = MODE_IDLE;
                n_num_acc  = '0;
                n_num_len  = '0;
                n_num_done = 1'b0;
                n_word_len = '0;
                n_line_tok = 1'b0;
            end else if (i_ch inside {" ", 8'd9, 8'd11, 8'd12, 8'd13}) begin
                tail_vld = 1'b0;
            end else if (is_digit(i_ch)) begin
                n_mode     = MODE_NUM;
                n_num_len  = NLW'(1);
                n_num_acc  = 14'(i_ch[3:0]);
                n_num_done = 1'b0;
            end else if (i_ch inside {"+", "-", "=", "*", "<", ">", "/"}) begin
                tail_vld   = 1'b1;
                tail_res   = mk(bll_pkg::KIND_OPER, 14'd0, i_ch);
                n_line_tok = 1'b1;
            end else if (is_letter(i_ch)) begin
                n_mode     = MODE_WORD;
                wr_en      = 1'b1;
                wr_idx     = '0;
                n_word_len = WLW'(1);
            end else if (i_ch == 8'h22) begin
                n_mode = MODE_QUOTE;
            end else if (i_ch == "(" || i_ch == ")") begin
                tail_vld   = 1'b1;
                tail_res   = mk(bll_pkg::KIND_BRACKET, 14'd0, i_ch);
                n_line_tok = 1'b1;
            end else if (i_ch == "#") begin
                tail_vld   = 1'b1;
                tail_res   = mk(bll_pkg::KIND_HASH, 14'd0, i_ch);
                n_line_tok = 1'b1;
            end else begin
                tail_vld = 1'b1;
                tail_res = mk(bll_pkg::KIND_ERROR, bll_pkg::ERR_SYMBOL, 8'd0);
                n_mode   = MODE_HALT;
            end
            if (tail_vld) begin
                if (res_cnt == 2'd0) begin
                    res0 = tail_res;
                end else begin
                    res1 = tail_res;
                end
                res_cnt = res_cnt + 2'd1;
            end
        end

        res0.last = (res_cnt == 2'd1);
        res1.last = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_IDLE;
            r_num_acc  <= '0;
            r_num_len  <= '0;
            r_num_done <= 1'b0;
            r_word_len <= '0;
            r_line_tok <= 1'b0;
        end else if (i_fire) begin
            r_mode     <= n_mode;
            r_num_acc  <= n_num_acc;
            r_num_len  <= n_num_len;
            r_num_done <= n_num_done;
            r_word_len <= n_word_len;
            r_line_tok <= n_line_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire && wr_en) begin
            r_word[wr_idx] <= wr_data;
        end
    end

    assign o_res0    = res0;
    assign o_res1    = res1;
    assign o_res_cnt = i_fire ? res_cnt : 2'd0;

endmodule

/* rtl/bll_ofifo.sv */
`include "basic_line_lexer_core_defines.svh"

module bll_ofifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  bll_pkg::t_res i_res0,
    input  bll_pkg::t_res i_res1,
    input  logic [1:0]    i_push_cnt,
    output logic          o_room2,
    output logic          o_valid,
    input  logic          i_ready,
    output bll_pkg::t_res o_res
);

    localparam int DEPTH = 4;
    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    bll_pkg::t_res  r_mem [DEPTH];
    logic [PW-1:0]  r_wr, n_wr;
    logic [PW-1:0]  r_rd, n_rd;
    logic [CW-1:0]  r_cnt, n_cnt;
    logic           pop;

    assign pop = o_valid && i_ready;

    always_comb begin
        n_wr  = r_wr + PW'(i_push_cnt);
        n_rd  = r_rd + PW'(pop);
        n_cnt = r_cnt + CW'(i_push_cnt) - CW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) begin
            r_mem[r_wr] <= i_res0;
        end
        if (i_push_cnt == 2'd2) begin
            r_mem[r_wr + PW'(1)] <= i_res1;
        end
    end

    assign o_room2 = (r_cnt <= CW'(DEPTH - 2));
    assign o_valid = (r_cnt != '0);
    assign o_res   = r_mem[r_rd];

    `BLL_ASSERT_IMPL(a_cnt_bound, i_clk, i_rst_n, 1'b1, r_cnt <= CW'(DEPTH), "fifo overflow")
    `BLL_ASSERT_IMPL(a_push_room, i_clk, i_rst_n, i_push_cnt != 2'd0,
        (r_cnt + CW'(i_push_cnt)) <= CW'(DEPTH), "push without room")
    `BLL_ASSERT_NEXT(a_pair_lands, i_clk, i_rst_n, (r_cnt == '0) && (i_push_cnt == 2'd2),
        (r_cnt == CW'(2)) && o_valid && !o_res.last, "result pair lost or misordered")

endmodule

/* bench/tb_basic_line_lexer_core.sv */
module tb_basic_line_lexer_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_NUM_CHARS  = 4;
    localparam int MAX_WORD_CHARS = 6;
    localparam int ITEM_TARGET    = 750;
    localparam int GAP_MAX        = 18;
    localparam int HOLD_START     = 150;
    localparam int HOLD_CYCLES    = 250;
    localparam int DRAIN_CYCLES   = 20;
    localparam int REPORT_LIMIT   = 10;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_NL    = 8'h0a;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_HASH  = "#";
    localparam logic [7:0] CH_SPACE = " ";
    localparam logic [7:0] CH_ZERO  = "0";

    typedef enum logic [2:0] {LX_IDLE, LX_NUM, LX_WORD, LX_QUOTE, LX_HALT} t_lex_mode;

    class t_lexer_scoreboard;
        t_lex_mode     mode;
        int            num_acc;
        int            num_len;
        bit            num_done;
        logic [7:0]    word_chars [8];
        int            word_len;
        bit            line_has_token;
        string         kw_names [8];
        bll_pkg::t_res tokens_q [$];
        bll_pkg::t_res fresh [$];
        int            chars_seen;
        int            live_chars;
        int            tokens_checked;
        int            error_tokens;
        int            mismatches;

        function new();
            kw_names = '{"input", "print", "let", "if", "goto", "end", "gosub", "return"};
            foreach (word_chars[i]) word_chars[i] = 8'h00;
            clear_line();
        endfunction

        function void clear_line();
            mode = LX_IDLE;
            num_acc = 0;
            num_len = 0;
            num_done = 0;
            word_len = 0;
            line_has_token = 0;
        endfunction

        function void emit(logic [3:0] kind, logic [13:0] value, logic [7:0] symbol);
            bll_pkg::t_res t;
            t.kind = kind;
            t.value = value;
            t.symbol = symbol;
            t.last = 1'b0;
            fresh.push_back(t);
        endfunction

        function bit is_letter(logic [7:0] c);
            return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
        endfunction

        function bit is_digit(logic [7:0] c);
            return c >= "0" && c <= "9";
        endfunction

        function bit is_delim(logic [7:0] c);
            return c inside {"(", ")", "=", "/", "*", "+", "-", CH_SPACE, CH_NL, CH_NUL, CH_QUOTE};
        endfunction

        function int keyword_code();
            bit hit;
            for (int i = 0; i < 8; i++) begin
                if (kw_names[i].len() == word_len) begin
                    hit = 1;
                    for (int j = 0; j < word_len; j++)
                        if (kw_names[i][j] != word_chars[j]) hit = 0;
                    if (hit) return i;
                end
            end
            return -1;
        endfunction

        function void start_char(logic [7:0] c);
            if (c inside {CH_SPACE, 8'd9, 8'd11, 8'd12, 8'd13}) return;
            if (is_digit(c)) begin
                mode = LX_NUM;
                num_len = 1;
                num_acc = int'(c - CH_ZERO);
                num_done = 0;
            end else if (c inside {"+", "-", "=", "*", "<", ">", "/"}) begin
                emit(bll_pkg::KIND_OPER, 14'd0, c);
                line_has_token = 1;
            end else if (is_letter(c)) begin
                mode = LX_WORD;
                word_chars[0] = c;
                word_len = 1;
            end else if (c == CH_QUOTE) begin
                mode = LX_QUOTE;
            end else if (c == "(" || c == ")") begin
                emit(bll_pkg::KIND_BRACKET, 14'd0, c);
                line_has_token = 1;
            end else if (c == CH_HASH) begin
                emit(bll_pkg::KIND_HASH, 14'd0, c);
                line_has_token = 1;
            end else begin
                emit(bll_pkg::KIND_ERROR, bll_pkg::ERR_SYMBOL, 8'h00);
                mode = LX_HALT;
            end
        endfunction

        function void note_char(logic [7:0] c);
            bit            line_end;
            bit            done;
            int            code;
            bll_pkg::t_res t;
            fresh.delete();
            chars_seen++;
            if (mode != LX_HALT) live_chars++;
            line_end = (c == CH_NUL || c == CH_NL);
            done = 0;
            case (mode)
                LX_HALT: begin
                    if (line_end) clear_line();
                    done = 1;
                end
                LX_QUOTE: begin
                    done = 1;
                    if (line_end) begin
                        emit(bll_pkg::KIND_ERROR, bll_pkg::ERR_QUOTE, 8'h00);
                        clear_line();
                    end else if (c == CH_QUOTE) begin
                        emit(bll_pkg::KIND_QEND, 14'd0, 8'h00);
                        mode = LX_IDLE;
                        line_has_token = 1;
                    end else begin
                        emit(bll_pkg::KIND_QCHAR, 14'd0, (c == CH_HASH) ? CH_NL : c);
                        line_has_token = 1;
                    end
                end
                LX_NUM: begin
                    if (!(line_end || is_delim(c) || is_letter(c))) begin
                        done = 1;
                        if (num_len >= MAX_NUM_CHARS) begin
                            emit(bll_pkg::KIND_ERROR, bll_pkg::ERR_NUMBER, 8'h00);
                            mode = LX_HALT;
                        end else begin
                            num_len++;
                            if (is_digit(c) && !num_done) begin
                                num_acc = num_acc * 10 + int'(c - CH_ZERO);
                                if (num_acc > int'(bll_pkg::NUM_CAP))
                                    num_acc = int'(bll_pkg::NUM_CAP);
                            end else begin
                                num_done = 1;
                            end
                        end
                    end else begin
                        emit(bll_pkg::KIND_NUMBER, num_acc[13:0], 8'h00);
                        line_has_token = 1;
                        mode = LX_IDLE;
                    end
                end
                LX_WORD: begin
                    if (!line_end && is_letter(c)) begin
                        done = 1;
                        if (word_len >= MAX_WORD_CHARS) begin
                            emit(bll_pkg::KIND_ERROR, bll_pkg::ERR_WORD, 8'h00);
                            mode = LX_HALT;
                        end else begin
                            word_chars[word_len] = c;
                            word_len++;
                        end
                    end else if (word_len == 1) begin
                        emit(bll_pkg::KIND_VAR, 14'd0, word_chars[0]);
                        line_has_token = 1;
                        word_len = 0;
                        mode = LX_IDLE;
                    end else begin
                        code = keyword_code();
                        if (code < 0) begin
                            emit(bll_pkg::KIND_ERROR, bll_pkg::ERR_KEYWORD, 8'h00);
                            mode = LX_HALT;
                            if (line_end) clear_line();
                            done = 1;
                        end else begin
                            emit(bll_pkg::KIND_KEYWORD, code[13:0], 8'h00);
                            line_has_token = 1;
                            word_len = 0;
                            mode = LX_IDLE;
                        end
                    end
                end
                default: ;
            endcase
            if (!done) begin
                if (line_end) begin
                    if (line_has_token) emit(bll_pkg::KIND_EOL, 14'd0, 8'h00);
                    clear_line();
                end else begin
                    start_char(c);
                end
            end
            for (int i = 0; i < fresh.size(); i++) begin
                t = fresh[i];
                t.last = (i == fresh.size() - 1);
                tokens_q.push_back(t);
            end
        endfunction

        function int pending();
            return tokens_q.size();
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= REPORT_LIMIT) $display("MISMATCH: %s", msg);
        endfunction

        function void check_token(bll_pkg::t_res got);
            bll_pkg::t_res want;
            tokens_checked++;
            if (got.kind == bll_pkg::KIND_ERROR) error_tokens++;
            if (tokens_q.size() == 0) begin
                flag($sformatf("unexpected token: kind %0d value %0d symbol 0x%0h last %0b",
                               got.kind, got.value, got.symbol, got.last));
                return;
            end
            want = tokens_q.pop_front();
            if (got.kind !== want.kind || got.value !== want.value ||
                got.symbol !== want.symbol || got.last !== want.last)
                flag($sformatf({"token %0d: expected kind %0d value %0d symbol 0x%0h last %0b,",
                                " got kind %0d value %0d symbol 0x%0h last %0b"},
                               tokens_checked, want.kind, want.value, want.symbol, want.last,
                               got.kind, got.value, got.symbol, got.last));
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [7:0]  i_ch = 8'h00;
    logic        i_ready = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [3:0]  o_kind;
    logic [13:0] o_value;
    logic [7:0]  o_symbol;
    logic        o_last;

    t_lexer_scoreboard sb = new();
    logic [7:0]      line_q [$];
    bit              hold_off = 1'b0;
    bit              send_calm = 1'b0;
    int              held_cycles = 0;
    string           oper_set = "+-=*<>/";
    string           junk_set = ".<>#:;";
    string           odd_set = "@!$;,?&%";
    logic [7:0]      blank_set [5] = '{8'd32, 8'd9, 8'd11, 8'd12, 8'd13};

    basic_line_lexer_core #(
        .MAX_NUMBER_CHARS(MAX_NUM_CHARS),
        .MAX_WORD_CHARS  (MAX_WORD_CHARS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_ch    (i_ch),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_kind  (o_kind),
        .o_value (o_value),
        .o_symbol(o_symbol),
        .o_last  (o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
    endfunction

    function automatic logic [7:0] rand_letter();
        if ($urandom_range(0, 1)) return 8'("a" + $urandom_range(0, 25));
        return 8'("A" + $urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] rand_digit();
        return 8'(CH_ZERO + $urandom_range(0, 9));
    endfunction

    function automatic void add_break();
        case ($urandom_range(0, 3))
            0, 1: line_q.push_back(CH_SPACE);
            2: line_q.push_back(oper_set[$urandom_range(0, 6)]);
            default: line_q.push_back(")");
        endcase
    endfunction

    function automatic void add_good_token();
        int         n;
        logic [7:0] c;
        case ($urandom_range(0, 7))
            0: begin
                add_text(sb.kw_names[$urandom_range(0, 7)]);
                add_break();
            end
            1: begin
                line_q.push_back(rand_letter());
                add_break();
            end
            2: begin
                n = $urandom_range(1, MAX_NUM_CHARS);
                line_q.push_back(rand_digit());
                for (int i = 1; i < n; i++) begin
                    if ($urandom_range(0, 4) == 0)
                        line_q.push_back(junk_set[$urandom_range(0, junk_set.len() - 1)]);
                    else
                        line_q.push_back(rand_digit());
                end
                add_break();
            end
            3: line_q.push_back(oper_set[$urandom_range(0, 6)]);
            4: line_q.push_back($urandom_range(0, 1) ? "(" : ")");
            5: line_q.push_back(CH_HASH);
            6: begin
                line_q.push_back(CH_QUOTE);
                n = $urandom_range(0, 5);
                repeat (n) begin
                    case ($urandom_range(0, 5))
                        0: c = CH_HASH;
                        1: begin
                            do c = 8'($urandom_range(1, 255));
                            while (c == CH_NL || c == CH_QUOTE);
                        end
                        default: begin
                            do c = 8'($urandom_range(32, 126));
                            while (c == CH_QUOTE);
                        end
                    endcase
                    line_q.push_back(c);
                end
                line_q.push_back(CH_QUOTE);
            end
            default: line_q.push_back(blank_set[$urandom_range(0, 4)]);
        endcase
    endfunction

    // returns 1 when the line must end right away (open quote)
    function automatic bit add_broken();
        case ($urandom_range(0, 4))
            0: repeat ($urandom_range(MAX_WORD_CHARS + 1, MAX_WORD_CHARS + 2))
                line_q.push_back(rand_letter());
            1: begin
                repeat ($urandom_range(2, MAX_WORD_CHARS)) line_q.push_back(rand_letter());
                line_q.push_back(CH_SPACE);
            end
            2: repeat ($urandom_range(MAX_NUM_CHARS + 1, MAX_NUM_CHARS + 2))
                line_q.push_back(rand_digit());
            3: begin
                line_q.push_back(CH_QUOTE);
                repeat ($urandom_range(0, 3)) line_q.push_back(rand_letter());
                return 1;
            end
            default: begin
                case ($urandom_range(0, 2))
                    0: line_q.push_back(odd_set[$urandom_range(0, odd_set.len() - 1)]);
                    1: line_q.push_back(8'($urandom_range(128, 255)));
                    default: line_q.push_back(8'($urandom_range(1, 8)));
                endcase
            end
        endcase
        return 0;
    endfunction

    function automatic void make_line();
        int pick;
        line_q.delete();
        pick = $urandom_range(0, 9);
        if (pick <= 6) begin
            repeat ($urandom_range(1, 6)) add_good_token();
        end else if (pick <= 8) begin
            repeat ($urandom_range(0, 2)) add_good_token();
            if (!add_broken()) repeat ($urandom_range(0, 3)) add_good_token();
        end else begin
            repeat ($urandom_range(1, 8)) line_q.push_back(8'($urandom_range(0, 255)));
        end
        line_q.push_back(($urandom_range(0, 3) == 0) ? CH_NUL : CH_NL);
    endfunction

    task automatic send_char(input logic [7:0] c);
        int gap;
        gap = (send_calm || hold_off) ? 0 : $urandom_range(0, GAP_MAX);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_ch <= c;
        do @(posedge i_clk); while (!o_ready);
        sb.note_char(c);
    endtask

    task automatic send_line();
        foreach (line_q[i]) send_char(line_q[i]);
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        line_q.delete();
        add_text("if(a)<9999.\"#\"");
        line_q.push_back(CH_NL);
        add_text("12345");
        line_q.push_back(CH_NL);
        add_text("\"z");
        line_q.push_back(CH_NUL);
        line_q.push_back(8'hff);
        line_q.push_back(CH_NL);
        send_line();

        while (sb.chars_seen < ITEM_TARGET) begin
            send_calm = ($urandom_range(0, 3) == 0);
            make_line();
            send_line();
        end
        i_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d characters (%0d outside halted lines), %0d tokens, %0d errors;",
                 sb.chars_seen, sb.live_chars, sb.tokens_checked, sb.error_tokens);
        $display("output held off for %0d cycles, %0d mismatches.", held_cycles, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("basic_line_lexer_core regression: pass");
        end else begin
            $display("basic_line_lexer_core regression: fail");
        end
        $finish;
    end

    initial begin
        int            stall;
        int            taken;
        bit            calm;
        bll_pkg::t_res got;
        taken = 0;
        calm = 0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (taken % 32 == 0) calm = ($urandom_range(0, 3) == 0);
            stall = calm ? 0 : $urandom_range(0, GAP_MAX);
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            while (hold_off) begin
                i_ready <= 1'b0;
                @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
            got.kind = o_kind;
            got.value = o_value;
            got.symbol = o_symbol;
            got.last = o_last;
            sb.check_token(got);
            taken++;
        end
    end

    // hold the output side so the block fills and backs up its input
    initial begin
        while (sb.chars_seen < HOLD_START) @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) begin
            @(posedge i_clk);
            held_cycles++;
        end
        hold_off <= 1'b0;
    end

    initial begin
        #5ms;
        $display("basic_line_lexer_core regression: fail");
        $finish;
    end

endmodule
